[rtl/hsv2rgb_pkg.sv]
// Shared constants, types and helpers for the HSV/HSL to RGB converter.
package hsv2rgb_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  localparam int CH_W  = 13;
  localparam int HUE_W = 17;
  localparam int ONE   = 1 << FRAC_BITS;

  localparam int HUE_PERIOD = 360 << HUE_FRAC_BITS;
  localparam int SECTOR_LEN = 60 << HUE_FRAC_BITS;
  localparam int SECTORS    = 6;

  // enough whole turns to lift the most negative hue to zero or above
  localparam int HUE_WRAPS  = (2 ** (HUE_W - 1) + HUE_PERIOD - 1) / HUE_PERIOD;
  localparam int HUE_OFFSET = HUE_WRAPS * HUE_PERIOD;
  localparam int U_MAX      = HUE_OFFSET + 2 ** (HUE_W - 1) - 1;
  localparam int U_W        = $clog2(U_MAX + 1);
  localparam int Q_W        = $clog2(U_MAX / SECTOR_LEN + 1);
  localparam int F_W        = $clog2(SECTOR_LEN + 1);
  localparam int PROD_W     = CH_W + F_W;
  localparam int M_W        = CH_W + 1;
  localparam int SUM_W      = CH_W + 2;

  // reciprocals of the sector length, rounded up; exact over the operand ranges used
  localparam int             Q_SHIFT = 30;
  localparam longint         Q_RECIP = ((64'sd1 <<< Q_SHIFT) + SECTOR_LEN - 1) / SECTOR_LEN;
  localparam int             RQ_W    = $clog2(Q_RECIP + 1);
  localparam int             X_SHIFT = 36;
  localparam longint         X_RECIP = ((64'sd1 <<< X_SHIFT) + SECTOR_LEN - 1) / SECTOR_LEN;
  localparam int             RX_W    = $clog2(X_RECIP + 1);

  // pipeline stages
  localparam int NSTAGE  = 6;
  localparam int ST_WRAP = 0;
  localparam int ST_DIV  = 1;
  localparam int ST_SECT = 2;
  localparam int ST_MUL  = 3;
  localparam int ST_XDIV = 4;
  localparam int ST_OUT  = 5;

  typedef enum logic {
    MODE_HSV = 1'b0,
    MODE_HSL = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
    logic [NSTAGE-1:0] valid;
  } pipe_ctl_t;

  // sector index modulo six by restoring subtraction of shifted multiples
  function automatic sector_t sector_of(input logic [Q_W-1:0] q);
    logic [Q_W+2:0] r;
    r = (Q_W + 3)'(q);
    for (int i = Q_W - 1; i >= 0; i--) begin
      if (r >= ((Q_W + 3)'(SECTORS) << i)) begin
        r = r - ((Q_W + 3)'(SECTORS) << i);
      end
    end
    return sector_t'(r[2:0]);
  endfunction

endpackage

[rtl/hsv2rgb_if.sv]
// Valid/ready channel interfaces for pixels in and RGB results out.
interface hsv2rgb_pix_if;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [16:0]      hue;
  logic        [12:0]      saturation;
  logic        [12:0]      brightness;
  logic        [12:0]      alpha_in;

  modport source(output valid, output mode, output hue, output saturation,
                 output brightness, output alpha_in, input ready);
  modport sink(input valid, input mode, input hue, input saturation,
               input brightness, input alpha_in, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic        valid;
  logic        ready;
  logic [12:0] red;
  logic [12:0] green;
  logic [12:0] blue;
  logic [12:0] alpha_out;

  modport source(output valid, output red, output green, output blue,
                 output alpha_out, input ready);
  modport sink(input valid, input red, input green, input blue,
               input alpha_out, output ready);
endinterface

[rtl/hsv2rgb_ctl.sv]
// Pipeline valid bits and per-stage load enables with bubble collapsing.
module hsv2rgb_ctl
  import hsv2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output pipe_ctl_t ctl
);

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] valid_next;
  logic [NSTAGE-1:0] upstream;
  logic [NSTAGE:0]   room;

  always_comb begin
    room[NSTAGE] = out_ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      room[k] = !valid[k] || room[k+1];
    end
  end

  assign upstream = {valid[NSTAGE-2:0], in_valid};

  always_comb begin
    for (int k = 0; k < NSTAGE; k++) begin
      valid_next[k] = room[k] ? upstream[k] : valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready  = room[0];
  assign ctl.load  = upstream & room[NSTAGE-1:0];
  assign ctl.valid = valid;

endmodule

[rtl/hsv2rgb_hue.sv]
// Hue path: wrap to a positive range, split into sector and in-sector position.
module hsv2rgb_hue
  import hsv2rgb_pkg::*;
(
  input  logic                    clk,
  input  pipe_ctl_t               ctl,
  input  logic signed [HUE_W-1:0] hue,
  output sector_t                 sector,
  output logic [F_W-1:0]          pos
);

  logic [U_W-1:0]      lifted;
  logic [U_W-1:0]      u0;
  logic [U_W-1:0]      u1;
  logic [U_W+RQ_W-1:0] qprod;
  logic [Q_W-1:0]      q1;
  logic [U_W-1:0]      base;
  logic [F_W-1:0]      rem;
  sector_t             sect;

  // hue plus whole turns is nonnegative, so its sector count taken mod 6 is the sector
  assign lifted = U_W'($unsigned({{(U_W - HUE_W){hue[HUE_W-1]}}, hue})) + U_W'(HUE_OFFSET);

  always_ff @(posedge clk) begin
    if (ctl.load[ST_WRAP]) begin
      u0 <= lifted;
    end
  end

  assign qprod = (U_W + RQ_W)'(u0) * (U_W + RQ_W)'(Q_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[ST_DIV]) begin
      q1 <= qprod[Q_SHIFT +: Q_W];
      u1 <= u0;
    end
  end

  assign base = U_W'(q1) * U_W'(SECTOR_LEN);
  assign rem  = F_W'(u1 - base);
  assign sect = sector_of(q1);

  always_ff @(posedge clk) begin
    if (ctl.load[ST_SECT]) begin
      sector <= sect;
      // odd sectors count down toward the next primary
      pos    <= sect[0] ? F_W'(SECTOR_LEN) - rem : rem;
    end
  end

endmodule

[rtl/hsv2rgb_chroma.sv]
// Chroma and offset path: clamp inputs, chroma product, offset m.
module hsv2rgb_chroma
  import hsv2rgb_pkg::*;
(
  input  logic                  clk,
  input  pipe_ctl_t             ctl,
  input  logic                  mode,
  input  logic [CH_W-1:0]       saturation,
  input  logic [CH_W-1:0]       brightness,
  output logic [CH_W-1:0]       chroma,
  output logic signed [M_W-1:0] offset
);

  logic [CH_W-1:0]   sat_cl;
  logic [CH_W-1:0]   br_cl;
  logic [CH_W:0]     twice;
  logic [CH_W:0]     lum_dev;
  logic [CH_W-1:0]   span;
  logic [CH_W-1:0]   a0;
  logic [CH_W-1:0]   s0;
  logic [CH_W-1:0]   br0;
  mode_t             mode0;
  logic [2*CH_W-1:0] cprod;
  logic [CH_W-1:0]   c1;
  logic [CH_W-1:0]   br1;
  mode_t             mode1;
  logic [CH_W-1:0]   sub;

  assign sat_cl = (saturation > CH_W'(ONE)) ? CH_W'(ONE) : saturation;
  assign br_cl  = (brightness > CH_W'(ONE)) ? CH_W'(ONE) : brightness;

  // HSL span is 1 - |2l - 1|
  assign twice   = {br_cl, 1'b0};
  assign lum_dev = (twice >= (CH_W + 1)'(ONE)) ? twice - (CH_W + 1)'(ONE)
                                               : (CH_W + 1)'(ONE) - twice;
  assign span    = CH_W'((CH_W + 1)'(ONE) - lum_dev);

  always_ff @(posedge clk) begin
    if (ctl.load[ST_WRAP]) begin
      mode0 <= mode_t'(mode);
      a0    <= (mode_t'(mode) == MODE_HSL) ? span : br_cl;
      s0    <= sat_cl;
      br0   <= br_cl;
    end
  end

  assign cprod = (2 * CH_W)'(a0) * (2 * CH_W)'(s0);

  always_ff @(posedge clk) begin
    if (ctl.load[ST_DIV]) begin
      c1    <= cprod[FRAC_BITS +: CH_W];
      br1   <= br0;
      mode1 <= mode0;
    end
  end

  assign sub = (mode1 == MODE_HSL) ? (c1 >> 1) : c1;

  always_ff @(posedge clk) begin
    if (ctl.load[ST_SECT]) begin
      chroma <= c1;
      offset <= $signed({1'b0, br1}) - $signed({1'b0, sub});
    end
  end

endmodule

[rtl/hsv_hsl_to_rgb.sv]
// HSV/HSL to RGB pixel converter, top level.
//
// Usage:
//   pix carries one pixel per transfer: mode (0 HSV, 1 HSL), hue in signed
//   1/64 degree, saturation, value or lightness and alpha in Q1.12.
//   rgb carries one result per transfer: red, green, blue saturated to
//   0..4096 and alpha copied from the pixel.
// Throughput: one pixel per clock while rgb.ready is high. The path is
//   six register stages: hue wrap, sector divide and chroma multiply,
//   sector split, x product, x divide by the sector length, placement
//   and saturation.
// Stalls: each stage loads when it is empty or its content moves on, so
//   holding rgb.ready low fills empty stages first; pix.ready drops only
//   when all six stages hold pixels. Nothing is dropped or repeated.
// Reset: rst (synchronous) empties the pipeline; pix.ready is high after it.
module hsv_hsl_to_rgb
  import hsv2rgb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  hsv2rgb_pix_if.sink   pix,
  hsv2rgb_rgb_if.source rgb
);

  pipe_ctl_t               ctl;
  logic                    in_ready;
  sector_t                 sector2;
  logic [F_W-1:0]          pos2;
  logic [CH_W-1:0]         c2;
  logic signed [M_W-1:0]   m2;

  logic [CH_W-1:0]         alpha_pipe [NSTAGE];

  logic [PROD_W-1:0]       p3;
  sector_t                 sector3;
  logic [CH_W-1:0]         c3;
  logic signed [M_W-1:0]   m3;

  logic [PROD_W+RX_W-1:0]  xprod;
  logic [CH_W-1:0]         x4;
  sector_t                 sector4;
  logic [CH_W-1:0]         c4;
  logic signed [M_W-1:0]   m4;

  logic [CH_W-1:0]         r_pre;
  logic [CH_W-1:0]         g_pre;
  logic [CH_W-1:0]         b_pre;
  logic [CH_W-1:0]         red;
  logic [CH_W-1:0]         green;
  logic [CH_W-1:0]         blue;

  function automatic logic [CH_W-1:0] add_sat(input logic [CH_W-1:0] comp,
                                              input logic signed [M_W-1:0] m);
    logic signed [SUM_W-1:0] sum;
    sum = $signed({2'b00, comp}) + $signed({{(SUM_W - M_W){m[M_W-1]}}, m});
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed(SUM_W'(ONE))) begin
      return CH_W'(ONE);
    end else begin
      return CH_W'(sum);
    end
  endfunction

  hsv2rgb_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (in_ready),
    .out_ready (rgb.ready),
    .ctl       (ctl)
  );

  hsv2rgb_hue u_hue (
    .clk    (clk),
    .ctl    (ctl),
    .hue    (pix.hue),
    .sector (sector2),
    .pos    (pos2)
  );

  hsv2rgb_chroma u_chroma (
    .clk        (clk),
    .ctl        (ctl),
    .mode       (pix.mode),
    .saturation (pix.saturation),
    .brightness (pix.brightness),
    .chroma     (c2),
    .offset     (m2)
  );

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      alpha_pipe[0] <= pix.alpha_in;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (ctl.load[k]) begin
        alpha_pipe[k] <= alpha_pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[ST_MUL]) begin
      p3      <= PROD_W'(c2) * PROD_W'(pos2);
      sector3 <= sector2;
      c3      <= c2;
      m3      <= m2;
    end
  end

  // divide by the sector length through its reciprocal
  assign xprod = (PROD_W + RX_W)'(p3) * (PROD_W + RX_W)'(X_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load[ST_XDIV]) begin
      x4      <= xprod[X_SHIFT +: CH_W];
      sector4 <= sector3;
      c4      <= c3;
      m4      <= m3;
    end
  end

  always_comb begin
    unique case (sector4)
      SEC_RED_YEL: begin r_pre = c4;  g_pre = x4;  b_pre = '0; end
      SEC_YEL_GRN: begin r_pre = x4;  g_pre = c4;  b_pre = '0; end
      SEC_GRN_CYN: begin r_pre = '0;  g_pre = c4;  b_pre = x4; end
      SEC_CYN_BLU: begin r_pre = '0;  g_pre = x4;  b_pre = c4; end
      SEC_BLU_MAG: begin r_pre = x4;  g_pre = '0;  b_pre = c4; end
      SEC_MAG_RED: begin r_pre = c4;  g_pre = '0;  b_pre = x4; end
      default:     begin r_pre = c4;  g_pre = '0;  b_pre = x4; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[ST_OUT]) begin
      red   <= add_sat(r_pre, m4);
      green <= add_sat(g_pre, m4);
      blue  <= add_sat(b_pre, m4);
    end
  end

  assign pix.ready     = in_ready;
  assign rgb.valid     = ctl.valid[ST_OUT];
  assign rgb.red       = red;
  assign rgb.green     = green;
  assign rgb.blue      = blue;
  assign rgb.alpha_out = alpha_pipe[ST_OUT];

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk) rst |=> !rgb.valid)
    else $error("output valid right after reset");

  a_x_le_chroma: assert property (@(posedge clk) disable iff (rst)
    ctl.valid[ST_XDIV] |-> (x4 <= c4))
    else $error("secondary component exceeds chroma");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    rgb.valid |-> (red <= CH_W'(ONE)) && (green <= CH_W'(ONE)) && (blue <= CH_W'(ONE)))
    else $error("color component above full scale");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !rgb.valid |-> pix.ready)
    else $error("input stalled with an empty output stage");
`endif

endmodule
